@@ hw/rtl/mbrtu_pkg.sv @@
// Shared types, constants and the CRC-16/Modbus byte step for the RTU poll master.
// No dependencies; every other file in hw/rtl except mbrtu_ifs uses this package.
`timescale 1ns / 1ps

package mbrtu_pkg;

    localparam int MAX_SENSORS    = 8;
    localparam int SENSOR_W       = $clog2(MAX_SENSORS);
    localparam int RESPONSE_BYTES = 13;
    localparam int RX_CNT_W       = 4;
    localparam int REQ_BYTES      = 8;
    localparam int TX_IDX_W       = 3;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
    localparam logic [7:0]  EXC_MASK       = 8'h80;
    localparam logic [7:0]  DATA_BYTES     = 8'd8;
    localparam logic [7:0]  REG_COUNT      = 8'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_SENSOR_COUNT = 3'd0;
    localparam logic [2:0] CFG_FIRST_ADDR   = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT      = 3'd2;
    localparam logic [2:0] CFG_RETRY        = 3'd3;
    localparam logic [2:0] CFG_OFFLINE_THR  = 3'd4;

    // poll outcome codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CRC     = 3'd1;
    localparam logic [2:0] ST_EXC     = 3'd2;
    localparam logic [2:0] ST_BCOUNT  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;

    localparam logic KIND_TX  = 1'b0;
    localparam logic KIND_REC = 1'b1;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_BYTE = 1'b1;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_REC,
        SEQ_TX
    } t_seq_state;

    typedef struct packed {
        logic        online;
        logic [7:0]  errors;
        logic [63:0] regs;
    } t_sensor;

    typedef struct packed {
        logic                kind;
        logic [7:0]          tx_byte;
        logic                last;
        logic [2:0]          sensor_index;
        logic [2:0]          status;
        logic                online;
        logic [7:0]          error_total;
        logic [63:0]         regs;
    } t_result;

    typedef struct packed {
        logic       done;
        logic [2:0] status;
    } t_rx_check;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/mbrtu_ifs.sv @@
// Valid/ready channel interfaces: poll items in, results out, configuration writes.
// Depends on nothing.
`timescale 1ns / 1ps

interface mbrtu_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;
    modport source (output valid, mode, rx_byte, input ready);
    modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface mbrtu_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  sensor_index;
    logic [2:0]  status;
    logic        online;
    logic [7:0]  error_total;
    logic [15:0] smoke_value;
    logic [15:0] water_value;
    logic [15:0] temperature_value;
    logic [15:0] humidity_value;
    modport source (output valid, kind, tx_byte, last, sensor_index, status, online,
                    error_total, smoke_value, water_value, temperature_value,
                    humidity_value, input ready);
    modport sink   (input valid, kind, tx_byte, last, sensor_index, status, online,
                    error_total, smoke_value, water_value, temperature_value,
                    humidity_value, output ready);
endinterface

interface mbrtu_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/mbrtu_sensor_mem.sv @@
// Per-sensor state memory (online flag, error count, four registers), registered read.
// Depends on mbrtu_pkg.
`timescale 1ns / 1ps

module mbrtu_sensor_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [mbrtu_pkg::SENSOR_W-1:0] i_rd_addr,
    output mbrtu_pkg::t_sensor            o_rd_data,
    input  logic                          i_wr_en,
    input  logic [mbrtu_pkg::SENSOR_W-1:0] i_wr_addr,
    input  mbrtu_pkg::t_sensor            i_wr_data
);

    mbrtu_pkg::t_sensor r_mem [mbrtu_pkg::MAX_SENSORS];
    logic [mbrtu_pkg::MAX_SENSORS-1:0] r_valid;
    mbrtu_pkg::t_sensor r_rd_data;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

@@ hw/rtl/mbrtu_rx_check.sv @@
// Response frame collector: running CRC, exception and byte-count flags, data bytes.
// Depends on mbrtu_pkg.
`timescale 1ns / 1ps

module mbrtu_rx_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clr,
    input  logic                  i_byte_en,
    input  logic [7:0]            i_byte,
    output mbrtu_pkg::t_rx_check  o_check,
    output logic [63:0]           o_regs
);

    logic [mbrtu_pkg::RX_CNT_W-1:0] r_count;
    logic [15:0] r_crc;
    logic        r_exc;
    logic        r_bc_ok;
    logic [63:0] r_data;
    logic [7:0]  r_crc_lo;
    logic        w_done;

    localparam logic [mbrtu_pkg::RX_CNT_W-1:0] LAST_IDX = mbrtu_pkg::RX_CNT_W'(mbrtu_pkg::RESPONSE_BYTES - 1);
    localparam logic [mbrtu_pkg::RX_CNT_W-1:0] CRC_LO_IDX = mbrtu_pkg::RX_CNT_W'(mbrtu_pkg::RESPONSE_BYTES - 2);

    assign w_done = i_byte_en && (r_count == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clr || w_done) begin
            r_count <= '0;
        end else if (i_byte_en) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_en) begin
            if (r_count == '0) begin
                r_crc <= mbrtu_pkg::crc_byte(mbrtu_pkg::CRC_INIT, i_byte);
            end else if (r_count < CRC_LO_IDX) begin
                r_crc <= mbrtu_pkg::crc_byte(r_crc, i_byte);
            end
            if (r_count == 4'd1) begin
                r_exc <= |(i_byte & mbrtu_pkg::EXC_MASK);
            end
            if (r_count == 4'd2) begin
                r_bc_ok <= (i_byte == mbrtu_pkg::DATA_BYTES);
            end
            if (r_count >= 4'd3 && r_count < CRC_LO_IDX) begin
                r_data <= {r_data[55:0], i_byte};
            end
            if (r_count == CRC_LO_IDX) begin
                r_crc_lo <= i_byte;
            end
        end
    end

    always_comb begin
        o_check.done = w_done;
        if ({i_byte, r_crc_lo} != r_crc) begin
            o_check.status = mbrtu_pkg::ST_CRC;
        end else if (r_exc) begin
            o_check.status = mbrtu_pkg::ST_EXC;
        end else if (!r_bc_ok) begin
            o_check.status = mbrtu_pkg::ST_BCOUNT;
        end else begin
            o_check.status = mbrtu_pkg::ST_OK;
        end
    end

    assign o_regs = r_data;

endmodule

@@ hw/rtl/modbus_rtu_poll_master_core.sv @@
// Top level of the Modbus RTU poll master: control state, result sequencer, output stage.
// Depends on mbrtu_pkg, mbrtu_ifs, mbrtu_sensor_mem and mbrtu_rx_check.
`timescale 1ns / 1ps

// An item that causes no result (most ticks, most received bytes) is taken as soon as it is
// valid and the next one may follow at once. An item that sends a request gives 8 tx-byte
// results, one per cycle after the accepting cycle while the sink does not stall; one that ends
// a poll puts a record result ahead of the request bytes, with the sensor state read from memory
// in the accepting cycle. The result sequencer emits one result per cycle into a single output
// register when the sink does not stall, and input ready is low while it runs: the next item is
// taken once the last result is in the output register, where it may still wait on the sink.

module modbus_rtu_poll_master_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mbrtu_in_if.sink         i_req,
    mbrtu_out_if.source      o_res,
    mbrtu_cfg_if.sink        i_cfg
);

    // configuration
    logic [3:0] r_sensor_count;
    logic [7:0] r_first_address;
    logic [7:0] r_timeout_ticks;
    logic [3:0] r_retry_limit;
    logic [7:0] r_offline_thr;

    // poll control
    logic                            r_phase;
    logic [mbrtu_pkg::SENSOR_W-1:0]  r_cur;
    logic [3:0]                      r_send_count;
    logic [7:0]                      r_wait_ticks;

    // sequencer
    mbrtu_pkg::t_seq_state           r_state, n_state;
    logic [mbrtu_pkg::SENSOR_W-1:0]  r_rec_sensor;
    logic [2:0]                      r_rec_status;
    logic [7:0]                      r_addr;
    logic [mbrtu_pkg::TX_IDX_W-1:0]  r_tx_idx;
    logic [15:0]                     r_tx_crc;

    // output stage
    logic                r_ov;
    mbrtu_pkg::t_result  r_o;

    logic                 w_accept, w_tick, w_rx_en, w_need_rec, w_need_tx, w_push;
    logic [7:0]           w_wt_inc;
    logic [3:0]           w_sc_inc, w_eff;
    logic [2:0]           w_status;
    logic [mbrtu_pkg::SENSOR_W-1:0] w_next;
    mbrtu_pkg::t_rx_check w_rx;
    logic [63:0]          w_rx_regs;
    mbrtu_pkg::t_sensor   w_rd, w_upd;
    logic                 w_wr_en;
    mbrtu_pkg::t_result   w_res;
    logic [7:0]           w_tx_byte;
    logic [8:0]           w_err_inc;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == mbrtu_pkg::SEQ_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_tick      = w_accept && (i_req.mode == mbrtu_pkg::MODE_TICK);
    assign w_rx_en     = w_accept && (i_req.mode == mbrtu_pkg::MODE_BYTE) && r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_count  <= 4'd4;
            r_first_address <= 8'd3;
            r_timeout_ticks <= 8'd50;
            r_retry_limit   <= 4'd3;
            r_offline_thr   <= 8'd3;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mbrtu_pkg::CFG_SENSOR_COUNT: r_sensor_count  <= i_cfg.data[3:0];
                mbrtu_pkg::CFG_FIRST_ADDR:   r_first_address <= i_cfg.data;
                mbrtu_pkg::CFG_TIMEOUT:      r_timeout_ticks <= i_cfg.data;
                mbrtu_pkg::CFG_RETRY:        r_retry_limit   <= i_cfg.data[3:0];
                mbrtu_pkg::CFG_OFFLINE_THR:  r_offline_thr   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    mbrtu_rx_check u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_tick && w_need_tx),
        .i_byte_en (w_rx_en),
        .i_byte    (i_req.rx_byte),
        .o_check   (w_rx),
        .o_regs    (w_rx_regs)
    );

    // decision for the accepted item
    always_comb begin
        w_wt_inc = (r_wait_ticks == 8'hFF) ? r_wait_ticks : r_wait_ticks + 8'd1;
        w_sc_inc = (r_send_count == 4'hF) ? r_send_count : r_send_count + 4'd1;
        if (r_sensor_count == 4'd0) begin
            w_eff = 4'd1;
        end else if (r_sensor_count > 4'(mbrtu_pkg::MAX_SENSORS)) begin
            w_eff = 4'(mbrtu_pkg::MAX_SENSORS);
        end else begin
            w_eff = r_sensor_count;
        end
        w_next = (({1'b0, r_cur} + 4'd1) >= w_eff) ? '0 : r_cur + 1'b1;
        w_need_rec = 1'b0;
        w_need_tx  = 1'b0;
        w_status   = mbrtu_pkg::ST_TIMEOUT;
        if (w_tick) begin
            if (!r_phase) begin
                w_need_tx = 1'b1;
            end else if (w_wt_inc >= r_timeout_ticks) begin
                w_need_tx  = 1'b1;
                w_need_rec = !(w_sc_inc < r_retry_limit);
            end
        end else if (w_rx_en && w_rx.done) begin
            w_need_tx  = 1'b1;
            w_need_rec = 1'b1;
            w_status   = w_rx.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= 1'b0;
            r_cur        <= '0;
            r_send_count <= '0;
            r_wait_ticks <= '0;
        end else begin
            if (w_tick && r_phase) begin
                r_wait_ticks <= w_wt_inc;
                if (w_wt_inc >= r_timeout_ticks) begin
                    r_send_count <= w_sc_inc;
                end
            end
            if (w_need_tx) begin
                r_phase      <= 1'b1;
                r_wait_ticks <= '0;
            end
            if (w_need_rec) begin
                r_send_count <= '0;
                r_cur        <= w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_need_tx) begin
            r_rec_sensor <= r_cur;
            r_rec_status <= w_status;
            r_addr       <= r_first_address + 8'(w_need_rec ? w_next : r_cur);
        end
    end

    // sensor state is read as the item is accepted; written back as the record leaves.
    // The sequencer blocks new items until the request is out, so no overlap on an entry.
    mbrtu_sensor_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_need_rec),
        .i_rd_addr (r_cur),
        .o_rd_data (w_rd),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_rec_sensor),
        .i_wr_data (w_upd)
    );

    assign w_push = (r_state != mbrtu_pkg::SEQ_IDLE) && (!r_ov || o_res.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mbrtu_pkg::SEQ_IDLE: begin
                if (w_need_rec) begin
                    n_state = mbrtu_pkg::SEQ_REC;
                end else if (w_need_tx) begin
                    n_state = mbrtu_pkg::SEQ_TX;
                end
            end
            mbrtu_pkg::SEQ_REC: begin
                if (w_push) begin
                    n_state = mbrtu_pkg::SEQ_TX;
                end
            end
            mbrtu_pkg::SEQ_TX: begin
                if (w_push && r_tx_idx == mbrtu_pkg::TX_IDX_W'(mbrtu_pkg::REQ_BYTES - 1)) begin
                    n_state = mbrtu_pkg::SEQ_IDLE;
                end
            end
            default: n_state = mbrtu_pkg::SEQ_IDLE;
        endcase
    end

    always_comb begin
        w_err_inc = {1'b0, w_rd.errors} + 9'd1;
        w_upd     = w_rd;
        if (r_rec_status == mbrtu_pkg::ST_OK) begin
            w_upd.online = 1'b1;
            w_upd.errors = '0;
            w_upd.regs   = w_rx_regs;
        end else begin
            w_upd.errors = w_err_inc[8] ? w_rd.errors : w_err_inc[7:0];
            if (w_upd.errors >= r_offline_thr) begin
                w_upd.online = 1'b0;
            end
        end
        case (r_tx_idx)
            3'd0:    w_tx_byte = r_addr;
            3'd1:    w_tx_byte = mbrtu_pkg::FUNC_READ_HOLD;
            3'd5:    w_tx_byte = mbrtu_pkg::REG_COUNT;
            3'd6:    w_tx_byte = r_tx_crc[7:0];
            3'd7:    w_tx_byte = r_tx_crc[15:8];
            default: w_tx_byte = 8'h00;
        endcase
        w_res   = '0;
        w_wr_en = 1'b0;
        case (r_state)
            mbrtu_pkg::SEQ_REC: begin
                w_wr_en            = w_push;
                w_res.kind         = mbrtu_pkg::KIND_REC;
                w_res.sensor_index = r_rec_sensor;
                w_res.status       = r_rec_status;
                w_res.online       = w_upd.online;
                w_res.error_total  = w_upd.errors;
                w_res.regs         = w_upd.regs;
            end
            mbrtu_pkg::SEQ_TX: begin
                w_res.kind    = mbrtu_pkg::KIND_TX;
                w_res.tx_byte = w_tx_byte;
                w_res.last    = (r_tx_idx == mbrtu_pkg::TX_IDX_W'(mbrtu_pkg::REQ_BYTES - 1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mbrtu_pkg::SEQ_IDLE;
            r_tx_idx <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mbrtu_pkg::SEQ_TX && w_push) begin
                r_tx_idx <= r_tx_idx + 1'b1;
            end
            if (w_push) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // request CRC built one byte per beat over the first six bytes
    always_ff @(posedge i_clk) begin
        if (r_state == mbrtu_pkg::SEQ_IDLE) begin
            r_tx_crc <= mbrtu_pkg::CRC_INIT;
        end else if (r_state == mbrtu_pkg::SEQ_TX && w_push && r_tx_idx < 3'd6) begin
            r_tx_crc <= mbrtu_pkg::crc_byte(r_tx_crc, w_tx_byte);
        end
        if (w_push) begin
            r_o <= w_res;
        end
    end

    assign o_res.valid             = r_ov;
    assign o_res.kind              = r_o.kind;
    assign o_res.tx_byte           = r_o.tx_byte;
    assign o_res.last              = r_o.last;
    assign o_res.sensor_index      = r_o.sensor_index;
    assign o_res.status            = r_o.status;
    assign o_res.online            = r_o.online;
    assign o_res.error_total       = r_o.error_total;
    assign o_res.smoke_value       = r_o.regs[63:48];
    assign o_res.water_value       = r_o.regs[47:32];
    assign o_res.temperature_value = r_o.regs[31:16];
    assign o_res.humidity_value    = r_o.regs[15:0];

endmodule

@@ hw/rtl/mbrtu_checker.sv @@
// Port-level checks on the result channel of the RTU poll master, bound to the top level.
// Depends on mbrtu_pkg and modbus_rtu_poll_master_core.
`timescale 1ns / 1ps

module mbrtu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_kind,
    input logic [7:0]  i_tx_byte,
    input logic        i_last,
    input logic [2:0]  i_sensor_index,
    input logic [2:0]  i_status,
    input logic [7:0]  i_error_total
);

    // a record is always followed by its request bytes
    a_rec_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == mbrtu_pkg::KIND_REC |-> !i_last)
        else $error("record flagged as last result");

    a_rec_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == mbrtu_pkg::KIND_REC |->
            (i_tx_byte == 8'd0) && (i_status == mbrtu_pkg::ST_OK ||
            i_status == mbrtu_pkg::ST_CRC || i_status == mbrtu_pkg::ST_EXC ||
            i_status == mbrtu_pkg::ST_BCOUNT || i_status == mbrtu_pkg::ST_TIMEOUT))
        else $error("bad record fields");

    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == mbrtu_pkg::KIND_TX |->
            i_sensor_index == 3'd0 && i_status == 3'd0 && i_error_total == 8'd0)
        else $error("tx result carries record fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_tx_byte) && $stable(i_kind))
        else $error("stalled result changed");

endmodule

bind modbus_rtu_poll_master_core mbrtu_checker u_mbrtu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_kind         (o_res.kind),
    .i_tx_byte      (o_res.tx_byte),
    .i_last         (o_res.last),
    .i_sensor_index (o_res.sensor_index),
    .i_status       (o_res.status),
    .i_error_total  (o_res.error_total)
);

@@ sim/testbench.sv @@
// Self-checking testbench for modbus_rtu_poll_master_core: directed and random polls,
// with a built-in predictor of the poll master. Depends on mbrtu_pkg, mbrtu_ifs and the RTL.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [2:0]  sensor_index;
        logic [2:0]  status;
        logic        online;
        logic [7:0]  error_total;
        logic [63:0] regs;      // {smoke, water, temperature, humidity}
    } t_poll_result;

    typedef enum int { FR_GOOD, FR_BAD_CRC, FR_EXCEPTION, FR_BAD_COUNT } t_frame_kind;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mbrtu_in_if  req_if();
    mbrtu_out_if res_if();
    mbrtu_cfg_if cfg_if();

    modbus_rtu_poll_master_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("** modbus_rtu_poll_master_core: FAILED **");
        $finish;
    end

    // predicted block state
    logic [3:0]  m_sensor_count;
    logic [7:0]  m_first_addr;
    logic [7:0]  m_timeout;
    logic [3:0]  m_retry;
    logic [7:0]  m_offline_thr;
    logic        m_polling;
    logic [2:0]  m_cur;
    logic [3:0]  m_sends;
    logic [7:0]  m_wait;
    logic [3:0]  m_rx_cnt;
    logic [7:0]  m_frame [13];
    logic [63:0] m_regs [mbrtu_pkg::MAX_SENSORS];
    logic        m_online [mbrtu_pkg::MAX_SENSORS];
    logic [7:0]  m_errors [mbrtu_pkg::MAX_SENSORS];

    t_poll_result expected_q[$];
    int  mismatches = 0;
    bit  calm = 0;          // no idling on either side
    int  rx_hold = 0;       // long receiver hold-off, in cycles

    function automatic logic [15:0] crc16_mb(input logic [7:0] f [13], input int n);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i < n; i++) begin
            c = c ^ {8'h00, f[i]};
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            end
        end
        return c;
    endfunction

    task automatic queue_request();
        logic [7:0]   f [13];
        logic [15:0]  c;
        t_poll_result r;
        foreach (f[i]) f[i] = 8'h00;
        f[0] = m_first_addr + 8'(m_cur);
        f[1] = mbrtu_pkg::FUNC_READ_HOLD;
        f[5] = mbrtu_pkg::REG_COUNT;
        c = crc16_mb(f, 6);
        f[6] = c[7:0];
        f[7] = c[15:8];
        for (int i = 0; i < mbrtu_pkg::REQ_BYTES; i++) begin
            r = '0;
            r.kind = mbrtu_pkg::KIND_TX;
            r.tx_byte = f[i];
            expected_q.push_back(r);
        end
        m_polling = 1'b1;
        m_wait = 0;
        m_rx_cnt = 0;
    endtask

    task automatic close_poll(input logic [2:0] st);
        t_poll_result r;
        int s;
        int active;
        s = m_cur;
        if (st == mbrtu_pkg::ST_OK) begin
            m_online[s] = 1'b1;
            m_errors[s] = 0;
            m_regs[s] = {m_frame[3], m_frame[4], m_frame[5], m_frame[6],
                         m_frame[7], m_frame[8], m_frame[9], m_frame[10]};
        end else begin
            if (m_errors[s] != 8'd255) m_errors[s] = m_errors[s] + 1;
            if (m_errors[s] >= m_offline_thr) m_online[s] = 1'b0;
        end
        r = '0;
        r.kind = mbrtu_pkg::KIND_REC;
        r.sensor_index = 3'(s);
        r.status = st;
        r.online = m_online[s];
        r.error_total = m_errors[s];
        r.regs = m_regs[s];
        expected_q.push_back(r);
        active = (m_sensor_count == 0) ? 1 :
                 (m_sensor_count > mbrtu_pkg::MAX_SENSORS) ? mbrtu_pkg::MAX_SENSORS :
                 int'(m_sensor_count);
        m_cur = (int'(m_cur) + 1 >= active) ? 3'd0 : m_cur + 3'd1;
        m_sends = 0;
        queue_request();
    endtask

    task automatic predict_item(input logic mode, input logic [7:0] b);
        int n0;
        logic [2:0] st;
        logic [15:0] cc;
        n0 = expected_q.size();
        if (!m_polling) begin
            if (mode == mbrtu_pkg::MODE_TICK) queue_request();
        end else if (mode == mbrtu_pkg::MODE_TICK) begin
            if (m_wait != 8'd255) m_wait = m_wait + 1;
            if (m_wait >= m_timeout) begin
                if (m_sends != 4'd15) m_sends = m_sends + 1;
                if (m_sends < m_retry) queue_request();
                else close_poll(mbrtu_pkg::ST_TIMEOUT);
            end
        end else begin
            if (m_rx_cnt < mbrtu_pkg::RESPONSE_BYTES) begin
                m_frame[m_rx_cnt] = b;
                m_rx_cnt = m_rx_cnt + 1;
            end
            if (m_rx_cnt >= mbrtu_pkg::RESPONSE_BYTES) begin
                cc = crc16_mb(m_frame, mbrtu_pkg::RESPONSE_BYTES - 2);
                if (cc != {m_frame[12], m_frame[11]}) st = mbrtu_pkg::ST_CRC;
                else if ((m_frame[1] & mbrtu_pkg::EXC_MASK) != 0) st = mbrtu_pkg::ST_EXC;
                else if (m_frame[2] != mbrtu_pkg::DATA_BYTES) st = mbrtu_pkg::ST_BCOUNT;
                else st = mbrtu_pkg::ST_OK;
                close_poll(st);
            end
        end
        if (expected_q.size() > n0) expected_q[$].last = 1'b1;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_poll_result got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.kind = res_if.kind;
            got.tx_byte = res_if.tx_byte;
            got.last = res_if.last;
            got.sensor_index = res_if.sensor_index;
            got.status = res_if.status;
            got.online = res_if.online;
            got.error_total = res_if.error_total;
            got.regs = {res_if.smoke_value, res_if.water_value,
                        res_if.temperature_value, res_if.humidity_value};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
    end

    // result receiver with random stalls
    initial begin
        int stall;
        res_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (rx_hold > 0) begin
                res_if.ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    task automatic send_item(input logic mode, input logic [7:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode <= mode;
        req_if.rx_byte <= b;
        do @(posedge i_clk); while (!req_if.ready);
        predict_item(mode, b);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            mbrtu_pkg::CFG_SENSOR_COUNT: m_sensor_count = data[3:0];
            mbrtu_pkg::CFG_FIRST_ADDR:   m_first_addr = data;
            mbrtu_pkg::CFG_TIMEOUT:      m_timeout = data;
            mbrtu_pkg::CFG_RETRY:        m_retry = data[3:0];
            mbrtu_pkg::CFG_OFFLINE_THR:  m_offline_thr = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] cnt, input logic [7:0] addr,
                              input logic [7:0] tmo, input logic [7:0] retry,
                              input logic [7:0] thr);
        write_reg(mbrtu_pkg::CFG_SENSOR_COUNT, cnt);
        write_reg(mbrtu_pkg::CFG_FIRST_ADDR, addr);
        write_reg(mbrtu_pkg::CFG_TIMEOUT, tmo);
        write_reg(mbrtu_pkg::CFG_RETRY, retry);
        write_reg(mbrtu_pkg::CFG_OFFLINE_THR, thr);
    endtask

    // one response frame addressed to the sensor being polled
    task automatic send_frame(input t_frame_kind fk, input logic [15:0] fill);
        logic [7:0]  f [13];
        logic [15:0] c;
        if (!m_polling) send_item(mbrtu_pkg::MODE_TICK, 8'($urandom));
        f[0] = m_first_addr + 8'(m_cur);
        f[1] = (fk == FR_EXCEPTION) ? (mbrtu_pkg::FUNC_READ_HOLD | mbrtu_pkg::EXC_MASK) :
                                      mbrtu_pkg::FUNC_READ_HOLD;
        f[2] = mbrtu_pkg::DATA_BYTES;
        if (fk == FR_BAD_COUNT)
            f[2] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) :
                                                 8'($urandom_range(9, 255));
        for (int i = 3; i < 11; i++)
            f[i] = (fill == 16'h0001) ? 8'($urandom) : (i[0] ? fill[15:8] : fill[7:0]);
        c = crc16_mb(f, 11);
        if (fk == FR_BAD_CRC) c = c ^ 16'($urandom_range(1, 65535));
        f[11] = c[7:0];
        f[12] = c[15:8];
        for (int i = 0; i < mbrtu_pkg::RESPONSE_BYTES; i++)
            send_item(mbrtu_pkg::MODE_BYTE, f[i]);
    endtask

    task automatic test_first_polls();
        send_item(mbrtu_pkg::MODE_BYTE, 8'hFF);        // byte while idle is dropped
        send_frame(FR_GOOD, 16'hFFFF);
        send_frame(FR_GOOD, 16'h0000);
    endtask

    task automatic test_frame_errors();
        send_frame(FR_BAD_CRC, 16'h0001);
        send_frame(FR_EXCEPTION, 16'h0001);
        send_frame(FR_BAD_COUNT, 16'h0001);
    endtask

    task automatic test_timeouts();
        // zero timeout, zero retry, zero threshold, address wrap, sensor count zero
        set_config(8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
        repeat (3) send_item(mbrtu_pkg::MODE_TICK, 8'h00);
        // count above range, long timeout with one send
        set_config(8'd15, 8'd247, 8'd40, 8'd1, 8'd255);
        repeat (45) send_item(mbrtu_pkg::MODE_TICK, 8'($urandom));
        set_config(8'd8, 8'd1, 8'd1, 8'd15, 8'd1);
        repeat (20) send_item(mbrtu_pkg::MODE_TICK, 8'h00);
    endtask

    task automatic test_backpressure();
        set_config(8'd3, 8'd10, 8'd2, 8'd2, 8'd2);
        rx_hold = 300;
        calm = 1;
        repeat (2) send_frame(FR_GOOD, 16'h0001);
        repeat (6) send_item(mbrtu_pkg::MODE_TICK, 8'h00);
        calm = 0;
        wait_drained();
    endtask

    task automatic test_random();
        int items;
        int pick;
        logic [7:0] thr;
        items = 0;
        while (items < 100) begin
            thr = 8'($urandom_range(1, 4));
            set_config(8'($urandom_range(1, 8)), 8'($urandom_range(1, 247)),
                       8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)), thr);
            for (int k = 0; k < 6; k++) begin
                calm = ($urandom_range(0, 4) == 0);
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    send_frame(FR_GOOD, 16'h0001);
                    items += 13;
                end else if (pick < 6) begin
                    send_frame(t_frame_kind'($urandom_range(1, 3)), 16'h0001);
                    items += 13;
                end else if (pick < 8) begin
                    repeat ($urandom_range(1, 10)) begin
                        send_item(mbrtu_pkg::MODE_TICK, 8'($urandom));
                        items++;
                    end
                end else begin
                    // broken frame or noise: a random mix of ticks and bytes
                    repeat ($urandom_range(1, 12)) begin
                        send_item(1'($urandom), 8'($urandom));
                        items++;
                    end
                end
            end
            calm = 0;
        end
    endtask

    initial begin
        m_sensor_count = 4;
        m_first_addr = 3;
        m_timeout = 50;
        m_retry = 3;
        m_offline_thr = 3;
        m_polling = 0;
        m_cur = 0;
        m_sends = 0;
        m_wait = 0;
        m_rx_cnt = 0;
        foreach (m_frame[i]) m_frame[i] = 0;
        for (int i = 0; i < mbrtu_pkg::MAX_SENSORS; i++) begin
            m_regs[i] = 0;
            m_online[i] = 0;
            m_errors[i] = 0;
        end
        req_if.valid = 1'b0;
        req_if.mode = mbrtu_pkg::MODE_TICK;
        req_if.rx_byte = 8'h00;
        cfg_if.valid = 1'b0;
        cfg_if.index = mbrtu_pkg::CFG_SENSOR_COUNT;
        cfg_if.data = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_polls();
        test_frame_errors();
        test_timeouts();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("** modbus_rtu_poll_master_core: PASSED **");
        end else begin
            $display("** modbus_rtu_poll_master_core: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/mbrtu_pkg.sv
hw/rtl/mbrtu_ifs.sv
hw/rtl/mbrtu_sensor_mem.sv
hw/rtl/mbrtu_rx_check.sv
hw/rtl/modbus_rtu_poll_master_core.sv
hw/rtl/mbrtu_checker.sv
sim/testbench.sv
